/* rtl/ptrs_pkg.sv */
// Package for the periodic task release scheduler.
// Holds the request and response word types and the request and task-state codes.
// Depends on nothing.
package ptrs_pkg;

   // Request codes carried in the req_type field.
   localparam logic [2:0] REQ_TIMER  = 3'd0;
   localparam logic [2:0] REQ_CREATE = 3'd1;
   localparam logic [2:0] REQ_DELETE = 3'd2;
   localparam logic [2:0] REQ_PAUSE  = 3'd3;
   localparam logic [2:0] REQ_RESUME = 3'd4;

   // Task states.
   localparam logic [1:0] ST_READY  = 2'd0;
   localparam logic [1:0] ST_PAUSED = 2'd1;
   localparam logic [1:0] ST_KILLED = 2'd2;

   // Largest number of releases reported for one OS tick.
   localparam int unsigned MAX_HITS = 8;
   // Width that holds any slot number the block supports.
   localparam int unsigned IDX_W = 4;
   // Width of the OS tick counter, which is also the dividend of the modulo.
   localparam int unsigned TICK_W = 32;
   localparam int unsigned PERIOD_W = 16;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  slot_index;
      logic [15:0] period_ticks;
      logic [7:0]  phase_offset;
      logic [1:0]  initial_state;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  released_slot;
      logic [31:0] tick_value;
      logic        last_release;
   } rsp_word_type;

endpackage

/* rtl/periodic_task_release_scheduler.sv */
// Periodic task release scheduler: top level with slot table, tick divider and walk sequencer.
// Depends on ptrs_pkg for the request and response word types and the codes.
//
// Usage:
//   A request word is taken at a rising edge where start is high and busy is low.
//   Create, delete, pause and resume update the slot table in that cycle and give no result.
//   A timer interrupt word counts down the divider; when it runs out, the OS tick counter
//   steps and the block walks the slots from the highest index down, with busy high.
//   Each slot that is valid, ready and has a nonzero period, while fewer than MAX_HITS
//   releases have been found, takes a check state, the shared restoring subtract unit (tick
//   mod period, one bit a cycle) and a compare state; any other slot takes only the check
//   state. The final release is registered out once the sequencer is back in idle.
//   Every release is one response word on rsp_word, shown for exactly one cycle with
//   rsp_valid high; the final release of a tick has last_release set. A release is shown
//   when the next one is found; the final one is sent once the walk has ended.
//   The receiver cannot stall.
//   csr_wr_en and csr_wr_data write the interrupts_per_tick register and reload the divider;
//   the user writes only while the block is idle (not enforced). A value of zero means 256.
//   Synchronous reset marks every slot invalid and ready, sets the divider and register to
//   one and the tick counter to zero; the block is ready as soon as reset is released.
module periodic_task_release_scheduler #(
   parameter int unsigned TASK_SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ptrs_pkg::req_word_type req_word,
   output logic                 rsp_valid,
   output ptrs_pkg::rsp_word_type rsp_word,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data
);
   import ptrs_pkg::*;

   localparam int unsigned SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int unsigned CNT_W = $clog2(TICK_W);
   localparam int unsigned HIT_W = $clog2(MAX_HITS + 1);

   // Sequencer codes.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_DIV   = 2'd2;
   localparam logic [1:0] S_CMP   = 2'd3;

   // Configuration, divider and tick counter.
   logic [7:0]        ipt_ff;
   logic [7:0]        div_ff;
   logic [TICK_W-1:0] tick_ff;

   // Slot table.
   logic                 valid_ff  [TASK_SLOTS];
   logic [1:0]           state_ff  [TASK_SLOTS];
   logic [PERIOD_W-1:0]  period_ff [TASK_SLOTS];
   logic [7:0]           offset_ff [TASK_SLOTS];

   // Walk sequencer and modulo unit.
   logic [1:0]          seq_ff, seq_in;
   logic [SLOT_W-1:0]   walk_ff, walk_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [TICK_W-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic [HIT_W-1:0]    hits_ff, hits_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pend_slot_ff, pend_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_ff, rsp_in;

   logic               accept;
   logic [IDX_W-1:0]   req_idx_wide;
   logic [SLOT_W-1:0]  req_idx;
   logic               req_idx_ok;
   logic [7:0]         div_dec;
   logic               tick_fire;
   logic               eligible;
   logic [PERIOD_W:0]  trial;
   logic               trial_ge;
   logic               hit;
   logic               walk_end;
   logic [IDX_W-1:0]   walk_wide;

   assign accept       = start && (seq_ff == S_IDLE);
   assign busy         = (seq_ff != S_IDLE);
   assign req_idx_wide = IDX_W'(req_word.slot_index);
   assign req_idx      = req_idx_wide[SLOT_W-1:0];
   assign req_idx_ok   = (req_idx_wide < IDX_W'(TASK_SLOTS));
   assign div_dec      = div_ff - 8'd1;
   assign tick_fire    = accept && (req_word.req_type == REQ_TIMER) && (div_dec == 8'd0);
   assign walk_wide    = IDX_W'(walk_ff);

   // Slot under the walk pointer may release only when valid, ready and with a period.
   assign eligible = valid_ff[walk_ff] && (state_ff[walk_ff] == ST_READY) &&
                     (period_ff[walk_ff] != '0);

   // One restoring step of tick mod period.
   assign trial    = {rem_ff, dvd_ff[TICK_W-1]};
   assign trial_ge = (trial >= {1'b0, period_ff[walk_ff]});

   assign hit      = (rem_ff == PERIOD_W'(offset_ff[walk_ff]));
   assign walk_end = (walk_ff == '0);

   // Divider, tick counter and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ipt_ff  <= 8'd1;
         div_ff  <= 8'd1;
         tick_ff <= '0;
      end else begin
         if (accept && (req_word.req_type == REQ_TIMER)) begin
            if (div_dec == 8'd0) begin
               div_ff  <= ipt_ff;
               tick_ff <= tick_ff + TICK_W'(1);
            end else begin
               div_ff <= div_dec;
            end
         end
         if (csr_wr_en) begin
            ipt_ff <= csr_wr_data;
            div_ff <= csr_wr_data;
         end
      end
   end

   // Slot table updates from create, delete, pause and resume words.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < TASK_SLOTS; s++) begin
            valid_ff[s] <= 1'b0;
            state_ff[s] <= ST_READY;
         end
      end else if (accept && req_idx_ok) begin
         unique case (req_word.req_type)
            REQ_CREATE: begin
               valid_ff[req_idx]  <= 1'b1;
               period_ff[req_idx] <= req_word.period_ticks;
               offset_ff[req_idx] <= req_word.phase_offset;
               state_ff[req_idx]  <= req_word.initial_state;
            end
            REQ_DELETE: begin
               valid_ff[req_idx] <= 1'b0;
               state_ff[req_idx] <= ST_KILLED;
            end
            REQ_PAUSE: begin
               state_ff[req_idx] <= ST_PAUSED;
            end
            REQ_RESUME: begin
               state_ff[req_idx] <= ST_READY;
            end
            default: begin
            end
         endcase
      end
   end

   // Walk sequencer: checks each slot, runs the modulo and reports releases one word behind.
   always_comb begin
      seq_in       = seq_ff;
      walk_in      = walk_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      hits_in      = hits_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      unique case (seq_ff)
         S_IDLE: begin
            if (tick_fire) begin
               seq_in  = S_CHECK;
               walk_in = SLOT_W'(TASK_SLOTS - 1);
               hits_in = '0;
               pend_in = 1'b0;
            end
         end
         S_CHECK: begin
            if (eligible && (hits_ff < HIT_W'(MAX_HITS))) begin
               seq_in = S_DIV;
               cnt_in = '0;
               dvd_in = tick_ff;
               rem_in = '0;
            end else if (walk_end) begin
               seq_in = S_IDLE;
            end else begin
               walk_in = walk_ff - SLOT_W'(1);
            end
         end
         S_DIV: begin
            dvd_in = {dvd_ff[TICK_W-2:0], 1'b0};
            if (trial_ge) begin
               rem_in = PERIOD_W'(trial - {1'b0, period_ff[walk_ff]});
            end else begin
               rem_in = PERIOD_W'(trial);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TICK_W - 1)) begin
               seq_in = S_CMP;
            end
         end
         S_CMP: begin
            if (hit) begin
               hits_in      = hits_ff + HIT_W'(1);
               pend_in      = 1'b1;
               pend_slot_in = walk_wide;
            end
            if (walk_end) begin
               seq_in = S_IDLE;
            end else begin
               seq_in  = S_CHECK;
               walk_in = walk_ff - SLOT_W'(1);
            end
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase

      // A pending release goes out when a newer one replaces it; the final one goes out
      // from idle once the walk has ended.
      if (pend_ff && (seq_ff == S_CMP) && hit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.released_slot  = pend_slot_ff[2:0];
         rsp_in.tick_value     = tick_ff;
         rsp_in.last_release   = 1'b0;
      end
      if ((seq_ff == S_IDLE) && pend_ff) begin
         rsp_valid_in          = 1'b1;
         rsp_in.released_slot  = pend_slot_ff[2:0];
         rsp_in.tick_value     = tick_ff;
         rsp_in.last_release   = 1'b1;
         pend_in               = 1'b0;
      end
   end

   // A release and a final release cannot both appear in one cycle: the final one is only
   // sent from idle, and the others only from a compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= S_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
      end else begin
         seq_ff       <= seq_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
      end
   end

   // Datapath registers of the walk.
   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      cnt_ff       <= cnt_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
